>>> hdl/xbcos_pkg.sv
// ----------------------------------------------------------------------------
// xbcos_pkg
// Shared constants, types and 6502 opcode tables for the block checksum scan.
// ----------------------------------------------------------------------------
package xbcos_pkg;

   localparam int unsigned BLOCK_BYTES_DEF = 128;
   localparam logic [7:0]  CODE_LENGTH_RST = 8'd114;
   localparam logic [7:0]  CODE_LENGTH_MIN = 8'd3;

   typedef enum logic [2:0] {
      CLS_OK = 3'd0,
      CLS_JM = 3'd1,
      CLS_IL = 3'd2,
      CLS_UN = 3'd3,
      CLS_NP = 3'd4,
      CLS_BR = 3'd5
   } op_class_type;

   // flag bit positions
   localparam int unsigned F_ILL   = 0;
   localparam int unsigned F_JAM   = 1;
   localparam int unsigned F_NOP   = 2;
   localparam int unsigned F_UNOP  = 3;
   localparam int unsigned F_FIRST = 4;

   typedef struct packed {
      logic checksum_ok;
      logic all_valid;
      logic jump_reached_clean;
      logic first_opcode_valid;
      logic saw_illegal;
      logic saw_jam;
      logic saw_nop;
      logic saw_unofficial_nop;
   } verdict_type;

   // registered input transaction handed to the scan stage
   typedef struct packed {
      logic [7:0] plain;
      logic       block_start;
   } item_type;

   function automatic op_class_type op_class(input logic [7:0] b);
      logic [3:0] lo;
      logic [3:0] hi;
      op_class_type c;
      lo = b[3:0];
      hi = b[7:4];
      c  = CLS_OK;
      if (lo == 4'h3 || lo == 4'h7 || lo == 4'hB || lo == 4'hF) c = CLS_IL;
      else if (lo == 4'h2) begin
         if (hi == 4'h0 || hi[0]) c = CLS_JM;
         else if (hi == 4'h8 || hi == 4'hC || hi == 4'hE) c = CLS_UN;
         else c = CLS_OK;
         if (hi == 4'h0 || hi == 4'h1 || hi == 4'h2 || hi == 4'h3 || hi == 4'h4 ||
             hi == 4'h5 || hi == 4'h6 || hi == 4'h7 || hi == 4'h9 || hi == 4'hB ||
             hi == 4'hD || hi == 4'hF) c = CLS_JM;
      end else if (lo == 4'h0) begin
         if (hi[0]) c = CLS_BR;
         else if (hi == 4'h2 || hi == 4'h4 || hi == 4'h6) c = CLS_BR;
         else if (hi == 4'h8) c = CLS_UN;
      end else if (lo == 4'h4) begin
         if (hi == 4'h0 || hi == 4'h1 || hi == 4'h3 || hi == 4'h4 || hi == 4'h5 ||
             hi == 4'h6 || hi == 4'h7 || hi == 4'hD || hi == 4'hF) c = CLS_UN;
      end else if (lo == 4'hC) begin
         if (hi == 4'h0 || hi == 4'h1 || hi == 4'h3 || hi == 4'h5 || hi == 4'h7 ||
             hi == 4'hD || hi == 4'hF) c = CLS_UN;
         else if (hi == 4'h4 || hi == 4'h6) c = CLS_BR;
         else if (hi == 4'h9) c = CLS_IL;
      end else if (lo == 4'hA) begin
         if (hi == 4'h1 || hi == 4'h3 || hi == 4'h5 || hi == 4'h7 || hi == 4'hD ||
             hi == 4'hF) c = CLS_UN;
         else if (hi == 4'hE) c = CLS_NP;
      end else if (lo == 4'h9) begin
         if (hi == 4'h8) c = CLS_UN;
      end else if (lo == 4'hE) begin
         if (hi == 4'h9) c = CLS_IL;
      end
      return c;
   endfunction

   function automatic logic [1:0] op_size(input logic [7:0] b);
      logic [3:0] lo;
      logic [3:0] hi;
      logic [1:0] s;
      lo = b[3:0];
      hi = b[7:4];
      case (lo)
         4'h0: s = (hi == 4'h0 || hi == 4'h4 || hi == 4'h6) ? 2'd1 :
                   (hi == 4'h2) ? 2'd3 : 2'd2;
         4'h1, 4'h5, 4'h6, 4'h4: s = 2'd2;
         4'h2: s = (hi == 4'h8 || hi == 4'hA || hi == 4'hC || hi == 4'hE) ? 2'd2 : 2'd0;
         4'h8, 4'hA: s = 2'd1;
         4'h9: s = hi[0] ? 2'd3 : 2'd2;
         4'hC: s = (hi == 4'h9) ? 2'd0 :
                   (hi[0] && hi != 4'h9 && hi != 4'hB) ? 2'd2 : 2'd3;
         4'hD: s = 2'd3;
         4'hE: s = (hi == 4'h9) ? 2'd0 : 2'd3;
         default: s = 2'd0;
      endcase
      return s;
   endfunction

endpackage

>>> hdl/xbcos_scan.sv
// ----------------------------------------------------------------------------
// xbcos_scan
// Block state: position, running sum, opcode walk and verdict register.
// ----------------------------------------------------------------------------
module xbcos_scan #(
   parameter int unsigned BLOCK_BYTES = xbcos_pkg::BLOCK_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             code_length,
   input  logic                   item_valid,
   input  xbcos_pkg::item_type    item,
   output logic                   vrd_valid,
   output xbcos_pkg::verdict_type vrd
);
   import xbcos_pkg::*;

   localparam int unsigned PW = $clog2(BLOCK_BYTES + 1);
   localparam logic [8:0] MAXLEN = 9'(BLOCK_BYTES);

   logic [PW-1:0] pos_ff, pos_in;
   logic [15:0]   sum_ff, sum_in;
   logic [1:0]    opl_ff, opl_in;
   logic          stop_ff, stop_in;
   logic          jmp_ff, jmp_in;
   logic          low_ff, low_in;
   logic [4:0]    flg_ff, flg_in;

   logic [8:0]    len;
   logic [8:0]    p;
   logic [PW-1:0] p0;
   logic [15:0]   s0;
   logic [1:0]    o0;
   logic          st0, j0, l0;
   logic [4:0]    f0;
   op_class_type  cls;
   logic [1:0]    sz;
   logic          fin;

   always_comb begin
      len = {1'b0, code_length};
      if (len < 9'(CODE_LENGTH_MIN)) len = 9'(CODE_LENGTH_MIN);
      if (len > MAXLEN) len = MAXLEN;
      if (item.block_start) begin
         p0 = '0; s0 = '0; o0 = '0; st0 = 1'b0; j0 = 1'b0; l0 = 1'b0; f0 = '0;
      end else begin
         p0 = pos_ff; s0 = sum_ff; o0 = opl_ff; st0 = stop_ff; j0 = jmp_ff;
         l0 = low_ff; f0 = flg_ff;
      end
      p      = 9'(p0);
      sum_in = s0; opl_in = o0; stop_in = st0; jmp_in = j0; low_in = l0; flg_in = f0;
      cls    = op_class(item.plain);
      sz     = op_size(item.plain);
      if (p + 9'd2 < len) begin
         sum_in = s0 + {8'd0, item.plain};
         if (!st0) begin
            if (o0 != 2'd0) opl_in = o0 - 2'd1;
            else if (cls == CLS_JM) begin
               flg_in[F_JAM] = 1'b1; stop_in = 1'b1;
            end else if (cls == CLS_IL) begin
               flg_in[F_ILL] = 1'b1; stop_in = 1'b1;
            end else begin
               if (cls == CLS_UN) flg_in[F_UNOP] = 1'b1;
               else if (cls == CLS_NP) flg_in[F_NOP] = 1'b1;
               else if (cls == CLS_BR) jmp_in = 1'b1;
               if (p == 9'd0) flg_in[F_FIRST] = 1'b1;
               opl_in = (sz != 2'd0) ? sz - 2'd1 : 2'd0;
            end
         end
      end else if (p + 9'd2 == len) begin
         low_in = (item.plain == s0[7:0]);
      end
      fin    = (p + 9'd1 >= len);
      pos_in = p0 + PW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; sum_ff <= '0; opl_ff <= '0; stop_ff <= 1'b0;
         jmp_ff <= 1'b0; low_ff <= 1'b0; flg_ff <= '0; vrd_valid <= 1'b0;
      end else begin
         vrd_valid <= item_valid && fin;
         if (item_valid) begin
            if (fin) begin
               pos_ff <= '0; sum_ff <= '0; opl_ff <= '0; stop_ff <= 1'b0;
               jmp_ff <= 1'b0; low_ff <= 1'b0; flg_ff <= '0;
            end else begin
               pos_ff <= pos_in; sum_ff <= sum_in; opl_ff <= opl_in;
               stop_ff <= stop_in; jmp_ff <= jmp_in; low_ff <= low_in;
               flg_ff <= flg_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid && fin) begin
         vrd.checksum_ok        <= l0 && (item.plain == s0[15:8]);
         vrd.all_valid          <= !f0[F_ILL] && !f0[F_JAM];
         vrd.jump_reached_clean <= j0;
         vrd.first_opcode_valid <= f0[F_FIRST];
         vrd.saw_illegal        <= f0[F_ILL];
         vrd.saw_jam            <= f0[F_JAM];
         vrd.saw_nop            <= f0[F_NOP];
         vrd.saw_unofficial_nop <= f0[F_UNOP];
      end
   end
endmodule

>>> hdl/xor_block_checksum_opcode_scan.sv
// ----------------------------------------------------------------------------
// xor_block_checksum_opcode_scan
// XOR decrypt, block checksum check and 6502 opcode scan with one verdict.
// ----------------------------------------------------------------------------
// One byte transaction per cycle. The verdict for a block passes the input
// register and then the verdict register before it enters a two-entry output
// queue, and rsp_tvalid rises once it is written there. req_tready drops only
// when the queue together with a verdict still in flight could overflow; with
// rsp_tready held high the input never stalls.
module xor_block_checksum_opcode_scan #(
   parameter int unsigned BLOCK_BYTES = xbcos_pkg::BLOCK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cipher_byte, key_byte
   input  logic        req_tuser,   // block_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // saw_unofficial_nop .. checksum_ok
);
   import xbcos_pkg::*;

   logic [7:0]  code_length_ff;
   logic        iv_ff;
   item_type    item_ff;
   logic        vv;
   verdict_type vrd;
   logic [7:0]  q_ff [2];
   logic [1:0]  cnt_ff;
   logic        rd_ff;
   logic        push, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) code_length_ff <= CODE_LENGTH_RST;
      else if (csr_valid) code_length_ff <= csr_data;
   end

   // ready leaves queue room for verdicts from the two stages in flight
   assign req_tready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !iv_ff && !vv) ||
                       (pop && !(iv_ff && vv));

   always_ff @(posedge clock) begin
      if (reset) iv_ff <= 1'b0;
      else iv_ff <= req_tvalid && req_tready;
      item_ff.plain       <= req_tdata[7:0] ^ req_tdata[15:8];
      item_ff.block_start <= req_tuser;
   end

   xbcos_scan #(.BLOCK_BYTES(BLOCK_BYTES)) u_scan (
      .clock(clock), .reset(reset), .code_length(code_length_ff),
      .item_valid(iv_ff), .item(item_ff), .vrd_valid(vv), .vrd(vrd));

   assign push       = vv;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
         if (pop) rd_ff <= ~rd_ff;
      end
      if (push) q_ff[rd_ff ^ cnt_ff[0]] <=
         {vrd.saw_unofficial_nop, vrd.saw_nop, vrd.saw_jam, vrd.saw_illegal,
          vrd.first_opcode_valid, vrd.jump_reached_clean, vrd.all_valid,
          vrd.checksum_ok};
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(cnt_ff == 2'd2 && push && !pop)) else $error("verdict queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("verdict count out of range");
   a_push_from_item: assert property (@(posedge clock) disable iff (reset)
      vv |-> $past(iv_ff)) else $error("verdict without an item");
endmodule
